>>> design/coherence_directory_controller_top_defines.svh
// Assertion macros shared by the directory controller checker.
// No dependencies; included by the checker file only.
`ifndef COHERENCE_DIRECTORY_CONTROLLER_TOP_DEFINES_SVH
`define COHERENCE_DIRECTORY_CONTROLLER_TOP_DEFINES_SVH

// Property checked while reset is released.
`define CDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define CDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/cdc_pkg.sv
// Shared types and constants for the coherence directory controller.
// No dependencies; imported by the top level, cdc_update and cdc_checker.
`timescale 1ns / 1ps

package cdc_pkg;

    localparam int LINE_BITS  = 10;
    localparam int LINE_DEPTH = 1 << LINE_BITS;
    localparam int CORES_DEF  = 8;
    localparam int CORE_ID_W  = 3;
    localparam int MASK_W     = 8;
    localparam int STATE_W    = 2;

    localparam logic CMD_REQ = 1'b0;

    typedef enum logic [STATE_W-1:0] {
        LS_INV = 2'd0,
        LS_SHR = 2'd1,
        LS_EXC = 2'd2
    } t_line_state;

    typedef enum logic [1:0] {
        CS_CLEAR  = 2'd0,
        CS_IDLE   = 2'd1,
        CS_LOOKUP = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        logic                 cmd;
        logic [CORE_ID_W-1:0] core_id;
        logic [LINE_BITS-1:0] line_addr;
        logic                 is_write;
        logic                 owner_modified;
    } t_in_item;

    typedef struct packed {
        logic               error;
        logic [STATE_W-1:0] prior_state;
        logic               mem_read;
        logic               mem_write;
        logic               send_read;
        logic               send_invalidate;
        logic [MASK_W-1:0]  target_mask;
    } t_out_item;

endpackage

>>> design/coherence_directory_controller_top.sv
// Top level of the coherence directory controller: sequencer, directory RAM, output register.
// Depends on cdc_pkg, cdc_ram and cdc_update.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | i_in  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready | o_out (t_out_item)
//
// Each item is accepted in CS_IDLE, which reads its directory entry from the RAM; in
// CS_LOOKUP the entry is updated, written back unless errored, and the output register loaded.
// After reset the RAM is swept to zero, one entry per cycle, with o_in_ready low
// until all 1 << LINE_BITS (1024) entries are cleared.
// A result waiting in the output register does not block acceptance; the update
// cycle holds only while the output register is still full.
`timescale 1ns / 1ps

module coherence_directory_controller_top
    import cdc_pkg::*;
#(
    parameter int CORES = CORES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int ENTRY_W = STATE_W + CORES;

    t_ctrl_state          r_state;
    t_ctrl_state          n_state;
    logic [LINE_BITS-1:0] r_clr_addr;
    logic [LINE_BITS-1:0] n_clr_addr;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_in_item             r_item;
    t_out_item            r_out;

    logic                 in_ready;
    logic                 accept;
    logic                 finish;
    logic                 ram_we;
    logic [LINE_BITS-1:0] ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 upd_wr_en;
    logic [STATE_W-1:0]   upd_state;
    logic [CORES-1:0]     upd_pres;
    t_out_item            upd_res;

    cdc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LINE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_in.line_addr),
        .o_rdata (ram_rdata)
    );

    cdc_update #(
        .CORES (CORES)
    ) u_update (
        .i_item      (r_item),
        .i_state     (ram_rdata[ENTRY_W-1 -: STATE_W]),
        .i_pres      (ram_rdata[CORES-1:0]),
        .o_wr_en     (upd_wr_en),
        .o_new_state (upd_state),
        .o_new_pres  (upd_pres),
        .o_res       (upd_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_CLEAR: begin
                if (r_clr_addr == LINE_BITS'(LINE_DEPTH - 1)) begin
                    n_state = CS_IDLE;
                end
            end
            CS_IDLE: begin
                if (i_in_valid) begin
                    n_state = CS_LOOKUP;
                end
            end
            CS_LOOKUP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_CLEAR;
            end
        endcase
    end

    // state outputs and RAM control
    always_comb begin
        in_ready   = 1'b0;
        finish     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_item.line_addr;
        ram_wdata  = {upd_state, upd_pres};
        n_clr_addr = r_clr_addr;
        case (r_state)
            CS_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + LINE_BITS'(1);
            end
            CS_IDLE: begin
                in_ready = 1'b1;
            end
            CS_LOOKUP: begin
                finish = !r_out_valid || i_out_ready;
                // errored items leave the entry untouched
                ram_we = finish && upd_wr_en;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept      = in_ready && i_in_valid;
    assign n_out_valid = finish || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
        if (finish) begin
            r_out <= upd_res;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> design/cdc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cdc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/cdc_update.sv
// Directory entry transition logic: new state, presence bits and result item.
// Depends on cdc_pkg.
`timescale 1ns / 1ps

module cdc_update
    import cdc_pkg::*;
#(
    parameter int CORES = CORES_DEF
) (
    input  t_in_item           i_item,
    input  logic [STATE_W-1:0] i_state,
    input  logic [CORES-1:0]   i_pres,
    output logic               o_wr_en,
    output logic [STATE_W-1:0] o_new_state,
    output logic [CORES-1:0]   o_new_pres,
    output t_out_item          o_res
);

    localparam logic [CORES-1:0] ONE = CORES'(1);

    logic               core_ok;
    logic [CORES-1:0]   me;
    logic [CORES-1:0]   owner;
    logic [CORES-1:0]   rest;
    logic               rest_single;
    logic               err;
    logic               mrd;
    logic               mwr;
    logic               srd;
    logic               sinv;
    logic [CORES-1:0]   tmask;
    logic [MASK_W-1:0]  tmask_out;
    logic [STATE_W-1:0] new_st;
    logic [CORES-1:0]   new_pres;

    always_comb begin
        core_ok     = int'(i_item.core_id) < CORES;
        me          = core_ok ? (ONE << i_item.core_id) : '0;
        // owner of an exclusive line is the lowest set presence bit
        owner       = i_pres & (~i_pres + ONE);
        rest        = i_pres & ~me;
        rest_single = (rest & (rest - ONE)) == '0;

        err      = 1'b0;
        mrd      = 1'b0;
        mwr      = 1'b0;
        srd      = 1'b0;
        sinv     = 1'b0;
        tmask    = '0;
        new_st   = i_state;
        new_pres = i_pres;

        if (!core_ok) begin
            err = 1'b1;
        end else if (i_item.cmd == CMD_REQ) begin
            case (i_state)
                LS_INV: begin
                    mrd      = !i_item.is_write;
                    new_pres = i_pres | me;
                    new_st   = LS_EXC;
                end
                LS_SHR: begin
                    if (!i_item.is_write) begin
                        srd      = 1'b1;
                        tmask    = i_pres;
                        new_pres = i_pres | me;
                    end else begin
                        sinv     = 1'b1;
                        tmask    = rest;
                        new_pres = me;
                        new_st   = LS_EXC;
                    end
                end
                LS_EXC: begin
                    if (owner == '0 || owner == me) begin
                        err = 1'b1;
                    end else begin
                        mwr   = i_item.owner_modified;
                        tmask = i_pres;
                        if (!i_item.is_write) begin
                            srd      = 1'b1;
                            new_st   = LS_SHR;
                            new_pres = i_pres | me;
                        end else begin
                            sinv     = 1'b1;
                            new_pres = (i_pres & ~owner) | me;
                        end
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end else begin
            case (i_state)
                LS_SHR: begin
                    // releasing sharer must be present and leave at least one sharer
                    if (i_item.is_write || (i_pres & me) == '0 || rest == '0) begin
                        err = 1'b1;
                    end else begin
                        new_pres = rest;
                        if (rest_single) begin
                            sinv   = 1'b1;
                            tmask  = rest;
                            new_st = LS_EXC;
                        end
                    end
                end
                LS_EXC: begin
                    if (i_pres == '0) begin
                        err = 1'b1;
                    end else begin
                        mwr      = i_item.is_write;
                        new_pres = '0;
                        new_st   = LS_INV;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end

        if (err) begin
            mrd   = 1'b0;
            mwr   = 1'b0;
            srd   = 1'b0;
            sinv  = 1'b0;
            tmask = '0;
        end
    end

    generate
        if (CORES >= MASK_W) begin : g_mask_trunc
            assign tmask_out = tmask[MASK_W-1:0];
        end else begin : g_mask_ext
            assign tmask_out = {{(MASK_W-CORES){1'b0}}, tmask};
        end
    endgenerate

    always_comb begin
        o_wr_en               = !err;
        o_new_state           = new_st;
        o_new_pres            = new_pres;
        o_res.error           = err;
        o_res.prior_state     = i_state;
        o_res.mem_read        = mrd;
        o_res.mem_write       = mwr;
        o_res.send_read       = srd;
        o_res.send_invalidate = sinv;
        o_res.target_mask     = tmask_out;
    end

endmodule

>>> design/cdc_checker.sv
// Port-level checks for the coherence directory controller, bound to the top level.
// Depends on cdc_pkg and coherence_directory_controller_top_defines.svh.
`timescale 1ns / 1ps
`include "coherence_directory_controller_top_defines.svh"

module cdc_checker
    import cdc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out
);

    logic in_acc;
    logic out_err;
    logic out_any_action;
    logic out_mrd;
    logic out_mrd_ok;
    logic out_stall;

    assign in_acc         = i_in_valid && i_in_ready;
    assign out_err        = i_out_valid && i_out.error;
    assign out_any_action = i_out.mem_read || i_out.mem_write || i_out.send_read ||
                            i_out.send_invalidate || (i_out.target_mask != '0);
    assign out_mrd        = i_out_valid && i_out.mem_read;
    assign out_mrd_ok     = (i_out.prior_state == LS_INV) && !i_out.send_read &&
                            !i_out.send_invalidate;
    assign out_stall      = i_out_valid && !i_out_ready;

    // directory sweep keeps the input closed right after reset
    `CDC_ASSERT_ALWAYS(a_ready_low_after_reset, i_clk, !i_rst_n |=> !i_in_ready, "early ready")

    `CDC_ASSERT(a_one_item_at_a_time, i_clk, i_rst_n, in_acc |=> !i_in_ready, "ready after item")

    `CDC_ASSERT(a_error_no_actions, i_clk, i_rst_n, out_err |-> !out_any_action, "error w/ action")

    `CDC_ASSERT(a_mem_read_from_invalid, i_clk, i_rst_n, out_mrd |-> out_mrd_ok, "bad mem read")

    `CDC_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out_valid && $stable(i_out), "out moved")

endmodule

bind coherence_directory_controller_top cdc_checker u_cdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);
